// ----- rtl/tvsg_pkg.sv -----
package tvsg_pkg;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_IDLE  = 2'd3
	} mode_t;

	localparam logic [3:0] REG_TONE_A_FINE = 4'd0;
	localparam logic [3:0] REG_NOISE       = 4'd6;
	localparam logic [3:0] REG_MIXER       = 4'd7;
	localparam logic [3:0] REG_LEVEL_A     = 4'd8;
	localparam logic [3:0] REG_ENV_FINE    = 4'd11;
	localparam logic [3:0] REG_ENV_COARSE  = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE   = 4'd13;
	localparam logic [3:0] REG_PORT_A      = 4'd14;
	localparam logic [3:0] REG_PORT_B      = 4'd15;

	localparam int NUM_VOICES = 3;

	localparam logic [7:0] PORT_B_IDLE     = 8'hFF;
	localparam logic [7:0] NOISE_BUSY_MASK = 8'h7E;
	localparam logic [7:0] NOISE_PHASE     = 8'h80;
	localparam logic [16:0] LFSR_RESET     = 17'h0FFFF;
	localparam logic [4:0] ENV_TOP         = 5'd31;
	localparam logic [4:0] ENV_BOTTOM      = 5'd0;

	typedef enum logic [2:0] {
		ENV_FALL = 3'b001,
		ENV_HOLD = 3'b010,
		ENV_RISE = 3'b100
	} env_dir_t;

	typedef struct packed {
		logic [NUM_VOICES-1:0][11:0] tone_period;
		logic [4:0]                  noise_period;
		logic [7:0]                  mixer;
		logic [NUM_VOICES-1:0][4:0]  level;
		logic [15:0]                 env_period;
		logic [3:0]                  env_shape;
	} settings_t;

	typedef struct packed {
		logic       restart;
		logic [3:0] shape;
	} env_ctl_t;

	typedef struct packed {
		logic [NUM_VOICES-1:0] tone;
		logic                  noise;
	} gen_levels_t;

	function automatic logic [7:0] reg_mask(input logic [3:0] addr);
		logic [7:0] m;
		case (addr)
			4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
			4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
			default:                 m = 8'hFF;
		endcase
		return m;
	endfunction

	function automatic logic [15:0] amp_level(input logic [3:0] lvl);
		logic [15:0] a;
		case (lvl)
			4'd0:    a = 16'd0;
			4'd1:    a = 16'd300;
			4'd2:    a = 16'd447;
			4'd3:    a = 16'd635;
			4'd4:    a = 16'd925;
			4'd5:    a = 16'd1351;
			4'd6:    a = 16'd1851;
			4'd7:    a = 16'd2991;
			4'd8:    a = 16'd3695;
			4'd9:    a = 16'd5782;
			4'd10:   a = 16'd7705;
			4'd11:   a = 16'd9829;
			4'd12:   a = 16'd12460;
			4'd13:   a = 16'd15014;
			4'd14:   a = 16'd18528;
			default: a = 16'd21845;
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/tvsg_regs.sv -----
module tvsg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [3:0]           addr,
	input  logic [7:0]           wr_data,
	input  logic [7:0]           port_pins,
	output logic [7:0]           rd_data,
	output tvsg_pkg::settings_t  settings,
	output tvsg_pkg::env_ctl_t   env_ctl
);

	logic [15:0][7:0] regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_en) begin
			regs_q[addr] <= wr_data & tvsg_pkg::reg_mask(addr);
		end
	end

	always_comb begin
		case (addr)
			tvsg_pkg::REG_PORT_A: rd_data = port_pins;
			tvsg_pkg::REG_PORT_B: rd_data = regs_q[tvsg_pkg::REG_MIXER][7] ?
				regs_q[tvsg_pkg::REG_PORT_B] : tvsg_pkg::PORT_B_IDLE;
			default:              rd_data = regs_q[addr];
		endcase
	end

	always_comb begin
		for (int c = 0; c < tvsg_pkg::NUM_VOICES; c++) begin
			settings.tone_period[c] = {regs_q[2*c+1][3:0], regs_q[2*c]};
			settings.level[c]       = regs_q[tvsg_pkg::REG_LEVEL_A + 4'(c)][4:0];
		end
		settings.noise_period = regs_q[tvsg_pkg::REG_NOISE][4:0];
		settings.mixer        = regs_q[tvsg_pkg::REG_MIXER];
		settings.env_period   = {regs_q[tvsg_pkg::REG_ENV_COARSE],
			regs_q[tvsg_pkg::REG_ENV_FINE]};
		settings.env_shape    = regs_q[tvsg_pkg::REG_ENV_SHAPE][3:0];
	end

	assign env_ctl.restart = wr_en && (addr == tvsg_pkg::REG_ENV_SHAPE);
	assign env_ctl.shape   = wr_data[3:0];

endmodule

// ----- rtl/tvsg_osc.sv -----
module tvsg_osc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick,
	input  tvsg_pkg::settings_t   settings,
	output tvsg_pkg::gen_levels_t levels
);

	logic [tvsg_pkg::NUM_VOICES-1:0][11:0] tone_count_q;
	logic [tvsg_pkg::NUM_VOICES-1:0]       tone_level_q;
	logic [7:0]                            noise_count_q;
	logic [16:0]                           lfsr_q;
	logic                                  noise_level_q;
	logic [7:0]                            noise_next;

	assign noise_next = (noise_count_q ^ tvsg_pkg::NOISE_PHASE) |
		{3'b000, settings.noise_period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_count_q <= '0;
			tone_level_q <= '0;
		end else if (tick) begin
			for (int c = 0; c < tvsg_pkg::NUM_VOICES; c++) begin
				if (tone_count_q[c][11:1] == 11'd0) begin
					tone_count_q[c] <= settings.tone_period[c];
					tone_level_q[c] <= !tone_level_q[c];
				end else begin
					tone_count_q[c] <= tone_count_q[c] - 12'd1;
				end
			end
		end
	end

	// The prescaler runs two half periods; the shift register steps once per full period.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_count_q <= '0;
			lfsr_q        <= tvsg_pkg::LFSR_RESET;
			noise_level_q <= 1'b0;
		end else if (tick) begin
			if ((noise_count_q & tvsg_pkg::NOISE_BUSY_MASK) == 8'd0) begin
				noise_count_q <= noise_next;
				if (!noise_next[7]) begin
					noise_level_q <= lfsr_q[15];
					lfsr_q        <= {lfsr_q[15:0], ~(lfsr_q[16] ^ lfsr_q[13])};
				end
			end else begin
				noise_count_q <= noise_count_q - 8'd1;
			end
		end
	end

	assign levels.tone  = tone_level_q;
	assign levels.noise = noise_level_q;

endmodule

// ----- rtl/tvsg_env.sv -----
module tvsg_env (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic [15:0]         period,
	input  tvsg_pkg::env_ctl_t  ctl,
	input  logic [3:0]          shape,
	output logic [4:0]          step
);

	logic [15:0]         count_q;
	logic [4:0]          step_q;
	tvsg_pkg::env_dir_t  dir_q;
	logic                hold, alt, att, cont;
	logic                at_end;

	assign hold = shape[0];
	assign alt  = shape[1];
	assign att  = shape[2];
	assign cont = shape[3];

	assign at_end = ((dir_q == tvsg_pkg::ENV_RISE) && (step_q == tvsg_pkg::ENV_TOP)) ||
		((dir_q == tvsg_pkg::ENV_FALL) && (step_q == tvsg_pkg::ENV_BOTTOM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			step_q  <= tvsg_pkg::ENV_TOP;
			dir_q   <= tvsg_pkg::ENV_FALL;
		end else if (ctl.restart) begin
			count_q <= period;
			step_q  <= ctl.shape[2] ? tvsg_pkg::ENV_BOTTOM : tvsg_pkg::ENV_TOP;
			dir_q   <= ctl.shape[2] ? tvsg_pkg::ENV_RISE : tvsg_pkg::ENV_FALL;
		end else if (tick) begin
			if (count_q[15:1] == 15'd0) begin
				count_q <= period;
				if (at_end) begin
					if (hold || !cont) begin
						step_q <= ((alt == att) || !cont) ? tvsg_pkg::ENV_BOTTOM :
							tvsg_pkg::ENV_TOP;
						dir_q  <= tvsg_pkg::ENV_HOLD;
					end else if (!alt) begin
						step_q <= (dir_q == tvsg_pkg::ENV_FALL) ? tvsg_pkg::ENV_TOP :
							tvsg_pkg::ENV_BOTTOM;
					end else if (dir_q == tvsg_pkg::ENV_RISE) begin
						dir_q  <= tvsg_pkg::ENV_FALL;
						step_q <= tvsg_pkg::ENV_TOP;
					end else begin
						dir_q  <= tvsg_pkg::ENV_RISE;
						step_q <= tvsg_pkg::ENV_BOTTOM;
					end
				end else begin
					case (dir_q)
						tvsg_pkg::ENV_RISE: step_q <= step_q + 5'd1;
						tvsg_pkg::ENV_FALL: step_q <= step_q - 5'd1;
						default:            step_q <= step_q;
					endcase
				end
			end else begin
				count_q <= count_q - 16'd1;
			end
		end
	end

	assign step = step_q;

	// After a restart the step sits at the end that the attack bit selects.
	a_restart_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.restart |=> (step_q == (($past(ctl.shape[2])) ? tvsg_pkg::ENV_BOTTOM :
			tvsg_pkg::ENV_TOP)))
		else $error("envelope restart did not load the start step");

endmodule

// ----- rtl/three_voice_sound_generator.sv -----
// Three-voice sound generator with a register bus. Each accepted word is a register
// write, a register read, one generator tick or an idle word, and each produces
// exactly one result word: a tick returns the summed amplitude of the three voices
// in audio_sample, a read returns the register value in read_data, and the other
// field is zero; other words return zeros. One word is accepted every clock cycle
// while req_stall is low. A two-entry output buffer lets the block keep taking one
// more word while a result waits, and req_stall rises only when both are full.
module three_voice_sound_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  reg_addr,
	input  logic [7:0]  write_data,
	input  logic [7:0]  port_pins,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] audio_sample,
	output logic [7:0]  read_data
);

	tvsg_pkg::settings_t   settings;
	tvsg_pkg::env_ctl_t    env_ctl;
	tvsg_pkg::gen_levels_t levels;
	tvsg_pkg::mode_t       op;
	logic                  accept, tick, wr_en, take_out;
	logic [7:0]            rd_data;
	logic [4:0]            env_step;
	logic [17:0]           sum;
	logic [15:0]           sample_res;
	logic [7:0]            read_res;

	logic                  rsp_valid_q, skid_valid_q;
	logic [15:0]           sample_q, skid_sample_q;
	logic [7:0]            read_q, skid_read_q;

	assign op     = tvsg_pkg::mode_t'(mode);
	assign accept = req_valid && !req_stall;
	assign tick   = accept && (op == tvsg_pkg::MODE_TICK);
	assign wr_en  = accept && (op == tvsg_pkg::MODE_WRITE);

	tvsg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.addr      (reg_addr),
		.wr_data   (write_data),
		.port_pins (port_pins),
		.rd_data   (rd_data),
		.settings  (settings),
		.env_ctl   (env_ctl)
	);

	tvsg_osc u_osc (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.settings (settings),
		.levels   (levels)
	);

	tvsg_env u_env (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.period (settings.env_period),
		.ctl    (env_ctl),
		.shape  (settings.env_shape),
		.step   (env_step)
	);

	always_comb begin
		sum = '0;
		for (int c = 0; c < tvsg_pkg::NUM_VOICES; c++) begin
			if ((levels.tone[c] || settings.mixer[c]) &&
				(levels.noise || settings.mixer[c+3])) begin
				sum = sum + {2'b00, tvsg_pkg::amp_level(settings.level[c][4] ?
					env_step[4:1] : settings.level[c][3:0])};
			end
		end
	end

	always_comb begin
		sample_res = '0;
		read_res   = '0;
		case (op)
			tvsg_pkg::MODE_TICK: sample_res = sum[15:0];
			tvsg_pkg::MODE_READ: read_res   = rd_data;
			default: begin
				sample_res = '0;
				read_res   = '0;
			end
		endcase
	end

	assign take_out  = rsp_valid_q && !rsp_stall;
	assign req_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!rsp_valid_q || take_out) begin
			if (skid_valid_q) begin
				rsp_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_valid_q || take_out) begin
			if (skid_valid_q) begin
				sample_q <= skid_sample_q;
				read_q   <= skid_read_q;
			end else if (accept) begin
				sample_q <= sample_res;
				read_q   <= read_res;
			end
		end else if (accept) begin
			skid_sample_q <= sample_res;
			skid_read_q   <= read_res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign audio_sample = sample_q;
	assign read_data    = read_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("buffered word without a word in the output register");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !rsp_valid_q) |=> rsp_valid_q)
		else $error("accepted word did not reach the output register");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (read_q != 8'd0)) |-> (sample_q == 16'd0))
		else $error("result word carries both a sample and read data");

endmodule

// ----- tb/testbench.sv -----
module testbench;

	localparam int HOLD_CYCLES = 200;
	localparam int WORDS_PER_PHASE = 270;
	localparam int SHAPE_HOLD = 0;
	localparam int SHAPE_ALT = 1;
	localparam int SHAPE_ATTACK = 2;
	localparam int SHAPE_CONT = 3;
	localparam int PORT_B_OUT = 7;

	typedef struct packed {
		tvsg_pkg::mode_t mode;
		logic [3:0]      addr;
		logic [7:0]      data;
		logic [7:0]      pins;
	} bus_word_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [7:0]  rdata;
	} out_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  mode = 2'd0;
	logic [3:0]  reg_addr = 4'd0;
	logic [7:0]  write_data = 8'd0;
	logic [7:0]  port_pins = 8'd0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [15:0] audio_sample;
	logic [7:0]  read_data;

	three_voice_sound_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.reg_addr(reg_addr),
		.write_data(write_data),
		.port_pins(port_pins),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.audio_sample(audio_sample),
		.read_data(read_data)
	);

	logic [15:0] amp_table [16] = '{
		16'd0, 16'd300, 16'd447, 16'd635, 16'd925, 16'd1351, 16'd1851, 16'd2991,
		16'd3695, 16'd5782, 16'd7705, 16'd9829, 16'd12460, 16'd15014, 16'd18528, 16'd21845
	};
	logic [7:0] write_mask [16] = '{
		8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h1F, 8'hFF,
		8'h1F, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF
	};

	logic [7:0]  gen_regs [16];
	logic [11:0] tone_cnt [tvsg_pkg::NUM_VOICES];
	logic [tvsg_pkg::NUM_VOICES-1:0] tone_lvl;
	logic [7:0]  noise_cnt;
	logic [16:0] noise_sr;
	logic        noise_lvl;
	logic [15:0] env_cnt;
	logic [4:0]  env_pos;
	tvsg_pkg::env_dir_t env_way;

	bus_word_t words_to_send [$];
	out_word_t predicted_outputs [$];
	bus_word_t on_bus;
	int        queued_count = 0;
	int        mismatches = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	logic      hold_go = 1'b0;
	logic      hold_seen;
	int        hold_left;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic model_reset();
		for (int i = 0; i < 16; i++)
			gen_regs[i] = 8'd0;
		for (int ch = 0; ch < tvsg_pkg::NUM_VOICES; ch++)
			tone_cnt[ch] = 12'd0;
		tone_lvl = '0;
		noise_cnt = 8'd0;
		noise_sr = tvsg_pkg::LFSR_RESET;
		noise_lvl = 1'b0;
		env_cnt = 16'd0;
		env_pos = tvsg_pkg::ENV_TOP;
		env_way = tvsg_pkg::ENV_FALL;
	endtask

	function automatic logic [15:0] voice_amp(input int ch);
		logic [7:0] lvl;
		lvl = gen_regs[tvsg_pkg::REG_LEVEL_A + ch];
		return lvl[4] ? amp_table[env_pos[4:1]] : amp_table[lvl[3:0]];
	endfunction

	task automatic gen_tick(output logic [15:0] sample);
		logic [7:0]  mix;
		logic [31:0] sum;
		logic [3:0]  shape;
		int          next_pos;
		int          step;
		mix = gen_regs[tvsg_pkg::REG_MIXER];
		sum = 0;
		for (int ch = 0; ch < tvsg_pkg::NUM_VOICES; ch++)
			if ((tone_lvl[ch] | mix[ch]) && (noise_lvl | mix[ch + 3]))
				sum = sum + 32'(voice_amp(ch));

		for (int ch = 0; ch < tvsg_pkg::NUM_VOICES; ch++) begin
			if (tone_cnt[ch] <= 12'd1) begin
				tone_cnt[ch] = {gen_regs[2 * ch + 1][3:0], gen_regs[2 * ch]};
				tone_lvl[ch] = ~tone_lvl[ch];
			end else begin
				tone_cnt[ch] = tone_cnt[ch] - 12'd1;
			end
		end

		if ((noise_cnt & tvsg_pkg::NOISE_BUSY_MASK) == 8'd0) begin
			noise_cnt = (noise_cnt ^ tvsg_pkg::NOISE_PHASE) | gen_regs[tvsg_pkg::REG_NOISE];
			if (!noise_cnt[7]) begin
				noise_lvl = noise_sr[15];
				noise_sr = {noise_sr[15:0], ~(noise_sr[16] ^ noise_sr[13])};
			end
		end else begin
			noise_cnt = noise_cnt - 8'd1;
		end

		if (env_cnt <= 16'd1) begin
			shape = gen_regs[tvsg_pkg::REG_ENV_SHAPE][3:0];
			env_cnt = {gen_regs[tvsg_pkg::REG_ENV_COARSE], gen_regs[tvsg_pkg::REG_ENV_FINE]};
			step = (env_way == tvsg_pkg::ENV_RISE) ? 1 :
				(env_way == tvsg_pkg::ENV_FALL) ? -1 : 0;
			next_pos = int'(env_pos) + step;
			if (next_pos < 0 || next_pos > 31) begin
				if (shape[SHAPE_HOLD] || !shape[SHAPE_CONT]) begin
					env_pos = (shape[SHAPE_ALT] == shape[SHAPE_ATTACK] || !shape[SHAPE_CONT])
						? tvsg_pkg::ENV_BOTTOM : tvsg_pkg::ENV_TOP;
					env_way = tvsg_pkg::ENV_HOLD;
				end else if (!shape[SHAPE_ALT]) begin
					env_pos = (next_pos < 0) ? tvsg_pkg::ENV_TOP : tvsg_pkg::ENV_BOTTOM;
				end else if (env_way == tvsg_pkg::ENV_RISE) begin
					env_way = tvsg_pkg::ENV_FALL;
					env_pos = tvsg_pkg::ENV_TOP;
				end else begin
					env_way = tvsg_pkg::ENV_RISE;
					env_pos = tvsg_pkg::ENV_BOTTOM;
				end
			end else begin
				env_pos = 5'(next_pos);
			end
		end else begin
			env_cnt = env_cnt - 16'd1;
		end
		sample = sum[15:0];
	endtask

	task automatic psg_step(input bus_word_t w, output out_word_t r);
		logic [15:0] sample;
		r = '0;
		case (w.mode)
			tvsg_pkg::MODE_TICK: begin
				gen_tick(sample);
				r.sample = sample;
			end
			tvsg_pkg::MODE_WRITE: begin
				gen_regs[w.addr] = w.data & write_mask[w.addr];
				if (w.addr == tvsg_pkg::REG_ENV_SHAPE) begin
					env_cnt = {gen_regs[tvsg_pkg::REG_ENV_COARSE],
						gen_regs[tvsg_pkg::REG_ENV_FINE]};
					if (gen_regs[tvsg_pkg::REG_ENV_SHAPE][SHAPE_ATTACK]) begin
						env_pos = tvsg_pkg::ENV_BOTTOM;
						env_way = tvsg_pkg::ENV_RISE;
					end else begin
						env_pos = tvsg_pkg::ENV_TOP;
						env_way = tvsg_pkg::ENV_FALL;
					end
				end
			end
			tvsg_pkg::MODE_READ: begin
				if (w.addr == tvsg_pkg::REG_PORT_A)
					r.rdata = w.pins;
				else if (w.addr == tvsg_pkg::REG_PORT_B &&
						!gen_regs[tvsg_pkg::REG_MIXER][PORT_B_OUT])
					r.rdata = tvsg_pkg::PORT_B_IDLE;
				else
					r.rdata = gen_regs[w.addr];
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		out_word_t predicted;
		bus_word_t next_word;
		if (!arst_n) begin
			req_valid <= 1'b0;
			model_reset();
		end else begin
			if (req_valid && !req_stall) begin
				psg_step(on_bus, predicted);
				predicted_outputs.push_back(predicted);
			end
			if (!req_valid || !req_stall) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = words_to_send.pop_front();
					on_bus <= next_word;
					mode <= next_word.mode;
					reg_addr <= next_word.addr;
					write_data <= next_word.data;
					port_pins <= next_word.pins;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			hold_left <= 0;
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		out_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (predicted_outputs.size() == 0) begin
				report_mismatch($sformatf("unexpected word sample=%0d read=%02h",
					audio_sample, read_data));
			end else begin
				want = predicted_outputs.pop_front();
				if (audio_sample !== want.sample)
					report_mismatch($sformatf("audio_sample %0d, expected %0d",
						audio_sample, want.sample));
				if (read_data !== want.rdata)
					report_mismatch($sformatf("read_data %02h, expected %02h",
						read_data, want.rdata));
			end
		end
	end

	task automatic push_word(input tvsg_pkg::mode_t m, input logic [3:0] a,
			input logic [7:0] d, input logic [7:0] p);
		bus_word_t w;
		w.mode = m;
		w.addr = a;
		w.data = d;
		w.pins = p;
		words_to_send.push_back(w);
		queued_count++;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (words_to_send.size() != 0 || req_valid || predicted_outputs.size() != 0);
	endtask

	initial begin : stimulus
		int target;
		int ticks;
		int pick;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 16; i++)
			push_word(tvsg_pkg::MODE_WRITE, 4'(i),
				(4'(i) == tvsg_pkg::REG_PORT_B) ? 8'h5A : 8'hFF, 8'h00);
		push_word(tvsg_pkg::MODE_READ, tvsg_pkg::REG_PORT_B, 8'h00, 8'h00);
		push_word(tvsg_pkg::MODE_TICK, 4'hF, 8'hFF, 8'hFF);
		push_word(tvsg_pkg::MODE_TICK, 4'h0, 8'h00, 8'h00);
		push_word(tvsg_pkg::MODE_WRITE, tvsg_pkg::REG_MIXER, 8'h00, 8'h00);
		push_word(tvsg_pkg::MODE_READ, tvsg_pkg::REG_PORT_B, 8'h00, 8'h00);
		push_word(tvsg_pkg::MODE_READ, tvsg_pkg::REG_PORT_A, 8'h00, 8'h00);
		push_word(tvsg_pkg::MODE_READ, tvsg_pkg::REG_PORT_A, 8'h00, 8'hFF);
		push_word(tvsg_pkg::MODE_READ, tvsg_pkg::REG_LEVEL_A, 8'h00, 8'h00);
		push_word(tvsg_pkg::MODE_IDLE, 4'hF, 8'hFF, 8'hFF);
		push_word(tvsg_pkg::MODE_WRITE, tvsg_pkg::REG_ENV_SHAPE, 8'h00, 8'h00);
		push_word(tvsg_pkg::MODE_TICK, 4'h0, 8'h00, 8'h00);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct <= 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 67;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					stall_pct <= 67;
				end
				default: begin
					send_idle_pct <= 23;
					stall_pct <= 23;
				end
			endcase
			target = queued_count + WORDS_PER_PHASE;
			while (queued_count < target) begin
				if ($urandom_range(99) < 80) begin
					if ($urandom_range(99) < 70)
						push_word(tvsg_pkg::MODE_WRITE, tvsg_pkg::REG_MIXER, 8'($urandom),
							8'($urandom));
					for (int ch = 0; ch < tvsg_pkg::NUM_VOICES; ch++) begin
						if ($urandom_range(99) < 70)
							push_word(tvsg_pkg::MODE_WRITE, 4'(2 * ch),
								8'($urandom_range(0, 24)), 8'($urandom));
						if ($urandom_range(99) < 30)
							push_word(tvsg_pkg::MODE_WRITE, 4'(2 * ch + 1),
								($urandom_range(99) < 20) ? 8'($urandom) : 8'h00, 8'($urandom));
						if ($urandom_range(99) < 70)
							push_word(tvsg_pkg::MODE_WRITE, 4'(tvsg_pkg::REG_LEVEL_A + ch),
								8'($urandom), 8'($urandom));
					end
					if ($urandom_range(99) < 70)
						push_word(tvsg_pkg::MODE_WRITE, tvsg_pkg::REG_NOISE, 8'($urandom),
							8'($urandom));
					push_word(tvsg_pkg::MODE_WRITE, tvsg_pkg::REG_ENV_FINE,
						8'($urandom_range(0, 3)), 8'($urandom));
					push_word(tvsg_pkg::MODE_WRITE, tvsg_pkg::REG_ENV_COARSE,
						($urandom_range(99) < 10) ? 8'($urandom) : 8'h00, 8'($urandom));
					push_word(tvsg_pkg::MODE_WRITE, tvsg_pkg::REG_ENV_SHAPE, 8'($urandom),
						8'($urandom));
					ticks = $urandom_range(20, 120);
					repeat (ticks) begin
						pick = $urandom_range(99);
						if (pick < 8)
							push_word(tvsg_pkg::MODE_READ, 4'($urandom), 8'($urandom),
								8'($urandom));
						else if (pick < 10)
							push_word(tvsg_pkg::MODE_WRITE, 4'($urandom), 8'($urandom),
								8'($urandom));
						else
							push_word(tvsg_pkg::MODE_TICK, 4'($urandom), 8'($urandom),
								8'($urandom));
					end
				end else begin
					repeat ($urandom_range(1, 8))
						push_word(tvsg_pkg::mode_t'(2'($urandom)), 4'($urandom),
							8'($urandom), 8'($urandom));
				end
			end
			// Hold the receiver off while the sender keeps offering words.
			if (phase == 0)
				hold_go <= ~hold_go;
			drain();
		end

		repeat (12) @(posedge clk);
		if (mismatches == 0 && predicted_outputs.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tvsg_pkg.sv
rtl/tvsg_regs.sv
rtl/tvsg_osc.sv
rtl/tvsg_env.sv
rtl/three_voice_sound_generator.sv
tb/testbench.sv
